// File: sv/rpt_pkg.sv
// ----------------------------------------------------------------------------
// rpt_pkg: shared types and codes of the reference-counted pin table
// Request and response payloads, status codes and the command and status
// groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package rpt_pkg;

	localparam int SLOTS_DEF      = 64;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic CMD_PIN     = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic [2:0] ST_NEW     = 3'd0;
	localparam logic [2:0] ST_RAISED  = 3'd1;
	localparam logic [2:0] ST_LOWERED = 3'd2;
	localparam logic [2:0] ST_FREED   = 3'd3;
	localparam logic [2:0] ST_UNKNOWN = 3'd4;
	localparam logic [2:0] ST_FULL    = 3'd5;

	typedef struct packed {
		logic        cmd;
		logic [63:0] handle;
	} req_t;

	typedef struct packed {
		logic [5:0]  slot_index;
		logic [15:0] ref_count;
		logic [2:0]  status;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan;
		logic pop;
		logic commit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic held;
		logic release_req;
		logic free_avail;
	} dp_sts_t;

endpackage

// File: sv/rpt_datapath.sv
// ----------------------------------------------------------------------------
// rpt_datapath: slot storage, key scan and table update
// Holds the slot entry memory (key and count), the free slot stack, the
// fill count and the response register. Steps are driven by the controller.
// ----------------------------------------------------------------------------
module rpt_datapath #(
	parameter int SLOTS      = rpt_pkg::SLOTS_DEF,
	parameter int COUNT_BITS = rpt_pkg::COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rpt_pkg::req_t    req,
	input  rpt_pkg::dp_cmd_t cmd,
	output rpt_pkg::dp_sts_t sts,
	output rpt_pkg::rsp_t    rsp
);
	import rpt_pkg::*;

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int ENT_W  = 64 + COUNT_BITS;
	localparam logic [SLOT_W:0]       SLOTS_N   = (SLOT_W + 1)'(SLOTS);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

	logic [ENT_W-1:0]  ent_mem [SLOTS];
	logic [SLOT_W-1:0] free_mem [SLOTS];

	req_t                  req_q;
	logic [SLOT_W:0]       grown_q;
	logic [SLOT_W:0]       depth_q;
	logic [SLOT_W:0]       issue_q;
	logic                  pend_q;
	logic [SLOT_W-1:0]     pend_idx_q;
	logic                  found_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [ENT_W-1:0]      ent_rd_q;
	logic [SLOT_W-1:0]     free_rd_q;
	rsp_t                  rsp_q;

	logic                  scan_done;
	logic                  hit;
	logic                  rd_en;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic [63:0]           rd_key;

	logic                  wr_en;
	logic [SLOT_W-1:0]     wr_addr;
	logic [COUNT_BITS-1:0] wr_cnt;
	logic                  push;
	logic                  take_free;
	logic                  grow;
	logic [SLOT_W-1:0]     res_slot;
	logic [COUNT_BITS-1:0] res_cnt;
	logic [2:0]            res_st;
	logic [COUNT_BITS-1:0] cnt_dec;
	logic [SLOT_W+5:0]     slot_ext;
	logic [COUNT_BITS+15:0] cnt_ext;

	assign rd_key = ent_rd_q[ENT_W-1 -: 64];
	assign rd_cnt = ent_rd_q[COUNT_BITS-1:0];

	// a slot matches only while its count is live
	assign hit       = pend_q && (rd_cnt != '0) && (rd_key == req_q.handle);
	assign scan_done = found_q || (!pend_q && (issue_q >= grown_q));
	assign rd_en     = cmd.scan && !scan_done && !hit && (issue_q < grown_q);

	assign sts.scan_done   = scan_done;
	assign sts.held        = found_q;
	assign sts.release_req = (req_q.cmd == CMD_RELEASE);
	assign sts.free_avail  = (depth_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= '0;
			pend_q  <= 1'b0;
			found_q <= 1'b0;
		end else if (cmd.load) begin
			issue_q <= '0;
			pend_q  <= 1'b0;
			found_q <= 1'b0;
		end else if (cmd.scan && !scan_done) begin
			if (hit) begin
				found_q <= 1'b1;
				pend_q  <= 1'b0;
			end else if (issue_q < grown_q) begin
				pend_q  <= 1'b1;
				issue_q <= issue_q + 1'b1;
			end else begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
		if (rd_en) begin
			pend_idx_q <= issue_q[SLOT_W-1:0];
		end
		if (cmd.scan && !scan_done && hit) begin
			slot_q <= pend_idx_q;
			cnt_q  <= rd_cnt;
		end
	end

	// entry memory: one read port for the scan, one write port for commit
	always_ff @(posedge clk) begin
		if (rd_en) begin
			ent_rd_q <= ent_mem[issue_q[SLOT_W-1:0]];
		end
		if (wr_en) begin
			ent_mem[wr_addr] <= {req_q.handle, wr_cnt};
		end
	end

	// free stack: top is read ahead of commit, pushes land at depth
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			free_rd_q <= free_mem[SLOT_W'(depth_q - 1'b1)];
		end
		if (push) begin
			free_mem[depth_q[SLOT_W-1:0]] <= slot_q;
		end
	end

	assign cnt_dec = COUNT_BITS'(cnt_q - 1'b1);

	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = slot_q;
		wr_cnt    = cnt_q;
		push      = 1'b0;
		take_free = 1'b0;
		grow      = 1'b0;
		res_slot  = '0;
		res_cnt   = '0;
		res_st    = ST_FULL;
		if (cmd.commit) begin
			if (req_q.cmd == CMD_PIN) begin
				if (found_q) begin
					if (cnt_q != COUNT_MAX) begin
						wr_en    = 1'b1;
						wr_cnt   = COUNT_BITS'(cnt_q + 1'b1);
						res_slot = slot_q;
						res_cnt  = wr_cnt;
						res_st   = ST_RAISED;
					end
				end else if (depth_q != '0) begin
					take_free = 1'b1;
					wr_en     = 1'b1;
					wr_addr   = free_rd_q;
					wr_cnt    = COUNT_ONE;
					res_slot  = free_rd_q;
					res_cnt   = COUNT_ONE;
					res_st    = ST_NEW;
				end else if (grown_q < SLOTS_N) begin
					grow     = 1'b1;
					wr_en    = 1'b1;
					wr_addr  = grown_q[SLOT_W-1:0];
					wr_cnt   = COUNT_ONE;
					res_slot = grown_q[SLOT_W-1:0];
					res_cnt  = COUNT_ONE;
					res_st   = ST_NEW;
				end
			end else if (!found_q) begin
				res_st = ST_UNKNOWN;
			end else begin
				wr_en    = 1'b1;
				wr_cnt   = cnt_dec;
				res_slot = slot_q;
				res_cnt  = cnt_dec;
				if (cnt_dec != '0) begin
					res_st = ST_LOWERED;
				end else begin
					res_st = ST_FREED;
					push   = (depth_q < SLOTS_N);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grown_q <= '0;
			depth_q <= '0;
		end else begin
			if (grow) begin
				grown_q <= grown_q + 1'b1;
			end
			if (take_free) begin
				depth_q <= depth_q - 1'b1;
			end else if (push) begin
				depth_q <= depth_q + 1'b1;
			end
		end
	end

	// mask to the response field widths
	assign slot_ext = {6'b0, res_slot};
	assign cnt_ext  = {16'b0, res_cnt};

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.slot_index <= slot_ext[5:0];
			rsp_q.ref_count  <= cnt_ext[15:0];
			rsp_q.status     <= res_st;
		end
	end

	assign rsp = rsp_q;

endmodule

// File: sv/rpt_ctrl.sv
// ----------------------------------------------------------------------------
// rpt_ctrl: request sequencer of the pin table
// Accepts a request, runs the key scan, reads the free stack when a new
// slot is needed, commits the update and holds the response valid.
// ----------------------------------------------------------------------------
module rpt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rpt_pkg::dp_cmd_t cmd,
	input  rpt_pkg::dp_sts_t sts
);
	import rpt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_POP,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	assign cmd.load   = (state_q == S_IDLE) && req_valid;
	assign cmd.scan   = (state_q == S_SCAN);
	assign cmd.pop    = (state_q == S_POP);
	assign cmd.commit = (state_q == S_COMMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (sts.scan_done) begin
						// a new pin with freed slots on hand takes the stack top
						if (!sts.release_req && !sts.held && sts.free_avail) begin
							state_q <= S_POP;
						end else begin
							state_q <= S_COMMIT;
						end
					end
				end
				S_POP: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					// hold until the response register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sv/refcount_pin_table_core.sv
// ----------------------------------------------------------------------------
// refcount_pin_table_core: reference-counted table of pinned 64-bit handles
// Request channel req (cmd, handle) and response channel rsp (slot_index,
// ref_count, status), both valid/ready; one response per request.
// A pin of a held handle raises its count, a pin of a new handle takes the
// top of the free stack or the next unused slot; a release lowers the count
// and frees the slot at zero. Unknown releases and full or overflow cases
// report a status and leave the table unchanged.
// One request at a time; the key scan covers only the slots taken into use
// so far (at most SLOTS), and a hit ends it early.
// The key scan reads one slot entry per cycle from the entry memory, which
// has one read port and one write port; a new pin from the free stack adds
// a stack read state before the commit.
// Reset empties the table at once: the fill count and stack depth clear,
// and entries beyond the fill count are never read. No clearing pass.
// A stalled response holds in the output register; the next request is
// taken and scanned meanwhile, and its commit waits for the register.
// ----------------------------------------------------------------------------
module refcount_pin_table_core #(
	parameter int SLOTS      = rpt_pkg::SLOTS_DEF,
	parameter int COUNT_BITS = rpt_pkg::COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  rpt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output rpt_pkg::rsp_t rsp
);
	import rpt_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	rpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rpt_datapath #(
		.SLOTS      (SLOTS),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

// File: test/tb_refcount_pin_table_core.sv
// ----------------------------------------------------------------------------
// tb_refcount_pin_table_core: self-checking bench for the pin table core
// Drives pin and release transactions on the request channel and checks
// every response against an in-bench model of the table (keys, counts,
// free stack, fill count). Directed tests cover extreme handles,
// free-stack reuse order and the full table. A long random run follows,
// with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_refcount_pin_table_core;
	timeunit 1ns;
	timeprecision 1ps;

	import rpt_pkg::*;

	localparam int          SLOTS          = SLOTS_DEF;
	localparam logic [15:0] COUNT_LIMIT    = 16'((1 << COUNT_BITS_DEF) - 1);
	localparam int          RANDOM_ITEMS   = 820;
	localparam int          POOL_MAX       = 96;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam logic [63:0] OVF_HANDLE     = 64'h0123_4567_89AB_CDEF;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// table model
	logic [63:0] tbl_key [SLOTS];
	logic [15:0] tbl_count [SLOTS];
	int          free_stack [SLOTS];
	int          free_top;
	int          slots_grown;

	rsp_t        pin_result_q [$];
	logic [63:0] handle_pool [$];
	int          error_count;
	int          idle_cycles;
	bit          no_idle;

	refcount_pin_table_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Update the table model with one request and return its response.
	function automatic rsp_t apply_pin_request(input req_t r);
		rsp_t res;
		int   hit;
		int   s;
		hit = -1;
		s   = 0;
		for (int i = 0; i < slots_grown; i++) begin
			if (hit < 0 && tbl_count[i] != 0 && tbl_key[i] == r.handle)
				hit = i;
		end
		res = '{slot_index: 6'd0, ref_count: 16'd0, status: ST_FULL};
		if (r.cmd == CMD_PIN) begin
			if (hit >= 0) begin
				if (tbl_count[hit] != COUNT_LIMIT) begin
					tbl_count[hit] = tbl_count[hit] + 16'd1;
					res = '{slot_index: 6'(hit), ref_count: tbl_count[hit],
						status: ST_RAISED};
				end
			end else if (free_top > 0 || slots_grown < SLOTS) begin
				if (free_top > 0) begin
					free_top--;
					s = free_stack[free_top];
				end else begin
					s = slots_grown;
					slots_grown++;
				end
				tbl_key[s]   = r.handle;
				tbl_count[s] = 16'd1;
				res = '{slot_index: 6'(s), ref_count: 16'd1, status: ST_NEW};
			end
		end else if (hit < 0) begin
			res = '{slot_index: 6'd0, ref_count: 16'd0, status: ST_UNKNOWN};
		end else begin
			tbl_count[hit] = tbl_count[hit] - 16'd1;
			if (tbl_count[hit] != 0) begin
				res = '{slot_index: 6'(hit), ref_count: tbl_count[hit],
					status: ST_LOWERED};
			end else begin
				tbl_key[hit] = '0;
				free_stack[free_top] = hit;
				free_top++;
				res = '{slot_index: 6'(hit), ref_count: 16'd0, status: ST_FREED};
			end
		end
		return res;
	endfunction

	task automatic send_request(input logic op, input logic [63:0] key);
		req_t r;
		int   gap;
		r   = '{cmd: op, handle: key};
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
		pin_result_q.push_back(apply_pin_request(r));
	endtask

	task automatic test_directed_cases();
		send_request(CMD_RELEASE, 64'h0);
		send_request(CMD_PIN, 64'h0);
		send_request(CMD_PIN, '1);
		send_request(CMD_PIN, 64'h0);
		send_request(CMD_PIN, 64'h8000_0000_0000_0000);
		send_request(CMD_PIN, 64'h1);
		send_request(CMD_RELEASE, 64'h0);
		send_request(CMD_RELEASE, 64'h0);
		send_request(CMD_RELEASE, 64'h0);
		send_request(CMD_RELEASE, 64'h8000_0000_0000_0000);
		// freed slots come back last-in first-out
		send_request(CMD_PIN, 64'h5555_5555_5555_5555);
		send_request(CMD_PIN, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(CMD_PIN, '1);
		send_request(CMD_RELEASE, '1);
		send_request(CMD_RELEASE, '1);
		send_request(CMD_RELEASE, 64'h1);
		send_request(CMD_PIN, 64'hFFFF_FFFF_FFFF_FFFE);
		send_request(CMD_PIN, 64'h7FFF_FFFF_FFFF_FFFF);
		send_request(CMD_PIN, 64'h0000_0001_0000_0000);
		send_request(CMD_RELEASE, 64'h0000_0000_0000_0001);
	endtask

	task automatic test_table_full();
		logic [63:0] key;
		while (slots_grown < SLOTS || free_top != 0) begin
			key = {$urandom, $urandom};
			handle_pool.push_back(key);
			send_request(CMD_PIN, key);
		end
		send_request(CMD_PIN, {$urandom, $urandom});
		send_request(CMD_RELEASE, {$urandom, $urandom});
		send_request(CMD_RELEASE, handle_pool[3]);
		send_request(CMD_RELEASE, handle_pool[10]);
		send_request(CMD_PIN, {$urandom, $urandom});
		send_request(CMD_PIN, handle_pool[3]);
		send_request(CMD_PIN, {$urandom, $urandom});
	endtask

	// Mostly known handles so counts and the free stack churn; some fresh noise.
	task automatic test_random_traffic();
		logic [63:0] key;
		logic        op;
		int          pick;
		handle_pool.push_back(OVF_HANDLE);
		handle_pool.push_back(64'h0);
		handle_pool.push_back('1);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				key = {$urandom, $urandom};
				op  = 1'($urandom_range(0, 1));
				if (op == CMD_PIN && handle_pool.size() < POOL_MAX)
					handle_pool.push_back(key);
			end else begin
				key = handle_pool[$urandom_range(0, handle_pool.size() - 1)];
				op  = (pick < 55) ? CMD_PIN : CMD_RELEASE;
			end
			send_request(op, key);
		end
		no_idle = 1'b0;
	endtask

	initial begin : response_check
		rsp_t want;
		int   stall;
		rsp_ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 8);
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			if (pin_result_q.size() == 0) begin
				flag_error($sformatf("response with none pending: slot %0d count %0d status %0d",
					rsp.slot_index, rsp.ref_count, rsp.status));
			end else begin
				want = pin_result_q.pop_front();
				if (rsp.slot_index !== want.slot_index)
					flag_error($sformatf("slot_index got %0d want %0d",
						rsp.slot_index, want.slot_index));
				if (rsp.ref_count !== want.ref_count)
					flag_error($sformatf("ref_count got %0d want %0d",
						rsp.ref_count, want.ref_count));
				if (rsp.status !== want.status)
					flag_error($sformatf("status got %0d want %0d",
						rsp.status, want.status));
			end
		end
	end

	// Stop the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		error_count = 0;
		no_idle     = 1'b0;
		free_top    = 0;
		slots_grown = 0;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_key[i]    = '0;
			tbl_count[i]  = '0;
			free_stack[i] = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_table_full();
		test_random_traffic();

		req_valid <= 1'b0;
		while (pin_result_q.size() != 0) @(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
sv/rpt_pkg.sv
sv/rpt_datapath.sv
sv/rpt_ctrl.sv
sv/refcount_pin_table_core.sv
test/tb_refcount_pin_table_core.sv
